// File: src/lfdt_pkg.sv
// Shared widths, codes and link types of the lowest-free descriptor table.
`default_nettype none

package lfdt_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [HANDLE_W-1:0] CON_IN  = HANDLE_W'(1);
  localparam logic [HANDLE_W-1:0] CON_OUT = HANDLE_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_DUP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Broadcast from the controller to every cell during a pass
  typedef struct packed {
    logic                clr_en;
    logic                wr_en;
    logic                scan_en;
    logic [SLOT_W-1:0]   addr_a;
    logic [SLOT_W-1:0]   addr_b;
    logic [SLOT_W-1:0]   wr_addr;
    logic [HANDLE_W-1:0] wr_data;
  } ctl_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] rd_a;
    logic [HANDLE_W-1:0] rd_b;
    logic                hunt;
    logic                found;
    logic [SLOT_W-1:0]   idx;
  } link_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic                release_res;
    logic [HANDLE_W-1:0] released_handle;
    logic                add_reference;
  } res_t;

  function automatic logic is_console(input logic [HANDLE_W-1:0] h);
    return (h == CON_IN) || (h == CON_OUT);
  endfunction

endpackage

`default_nettype wire

// File: src/lfdt_cell.sv
// One table slot: holds its handle and acts on the token as it passes.
`default_nettype none

module lfdt_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lfdt_pkg::ctl_t  ctl_i,
  input  wire lfdt_pkg::link_t link_i,
  output lfdt_pkg::link_t      link_o
);
  import lfdt_pkg::*;

  localparam logic [SLOT_W-1:0]   MY_IDX  = SLOT_W'(CELL_IDX);
  localparam logic [HANDLE_W-1:0] RST_VAL = (CELL_IDX == 0) ? CON_IN :
                                            (CELL_IDX == 1) ? CON_OUT : '0;

  logic [HANDLE_W-1:0] entry_q, entry_d;
  link_t               link_q, link_d;

  always_comb begin
    entry_d = entry_q;
    link_d  = link_i;
    if (link_i.valid) begin
      if (ctl_i.addr_a == MY_IDX) begin
        link_d.rd_a = entry_q;
      end
      if (ctl_i.addr_b == MY_IDX) begin
        link_d.rd_b = entry_q;
      end
      if (ctl_i.clr_en && (ctl_i.addr_a == MY_IDX)) begin
        entry_d = '0;
      end
      if (ctl_i.wr_en && (ctl_i.wr_addr == MY_IDX)) begin
        entry_d     = ctl_i.wr_data;
        link_d.hunt = ctl_i.scan_en;
      end else if (link_i.hunt && (entry_q == '0)) begin
        link_d.hunt  = 1'b0;
        link_d.found = 1'b1;
        link_d.idx   = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= RST_VAL;
      link_q  <= '0;
    end else begin
      entry_q <= entry_d;
      link_q  <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

`default_nettype wire

// File: src/lfdt_ctrl.sv
// Command sequencer: launches passes, tracks the free pointer, holds the result beat.
`default_nettype none

module lfdt_ctrl #(
  parameter int unsigned TABLE_DEPTH = lfdt_pkg::DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [lfdt_pkg::CMD_W-1:0]    command_i,
  input  wire logic [lfdt_pkg::HANDLE_W-1:0] handle_i,
  input  wire logic [lfdt_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [lfdt_pkg::SLOT_W-1:0]   target_slot_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [lfdt_pkg::STATUS_W-1:0]      status_o,
  output logic [lfdt_pkg::SLOT_W-1:0]        slot_out_o,
  output logic [lfdt_pkg::HANDLE_W-1:0]      handle_out_o,
  output logic                               release_res_o,
  output logic [lfdt_pkg::HANDLE_W-1:0]      released_handle_o,
  output logic                               add_reference_o,
  output lfdt_pkg::ctl_t                     ctl_o,
  output lfdt_pkg::link_t                    inject_o,
  input  wire lfdt_pkg::link_t               tail_i
);
  import lfdt_pkg::*;

  localparam int unsigned        PTR_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned        EXT_W     = SLOT_W + 1;
  localparam logic [PTR_W-1:0]   DEPTH_PTR = PTR_W'(TABLE_DEPTH);
  localparam logic [EXT_W-1:0]   DEPTH_EXT = EXT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS1,
    S_PASS2,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    nf_q, nf_d;
  ctl_t                ctl_q, ctl_d;
  logic                launch_q, launch_d;
  cmd_e                cmd_q, cmd_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SLOT_W-1:0]   tgt_q, tgt_d;
  res_t                res_q, res_d;
  res_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [EXT_W-1:0]    nf_ext;
  logic [EXT_W-1:0]    slot_ext;
  logic [EXT_W-1:0]    tgt_ext;
  logic                in_rng;
  logic                tgt_rng;
  logic [PTR_W-1:0]    nf_scan;
  logic [PTR_W-1:0]    nf_dup;

  assign nf_ext   = EXT_W'(nf_q);
  assign slot_ext = EXT_W'(slot_q);
  assign tgt_ext  = EXT_W'(tgt_q);
  assign in_rng   = EXT_W'(slot_i) < DEPTH_EXT;
  assign tgt_rng  = tgt_ext < DEPTH_EXT;
  assign nf_scan  = tail_i.found ? PTR_W'(tail_i.idx) : DEPTH_PTR;
  assign nf_dup   = ((tail_i.rd_b != '0) && (tgt_ext < nf_ext)) ? PTR_W'(tgt_q) : nf_q;

  always_comb begin
    state_d     = state_q;
    nf_d        = nf_q;
    ctl_d       = ctl_q;
    launch_d    = 1'b0;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    tgt_d       = tgt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_e'(command_i);
          slot_d       = slot_i;
          tgt_d        = target_slot_i;
          res_d        = '0;
          ctl_d        = '0;
          ctl_d.addr_a = slot_i;
          ctl_d.addr_b = target_slot_i;
          state_d      = S_PASS1;
          launch_d     = 1'b1;
          unique case (cmd_e'(command_i))
            CMD_ALLOC: begin
              if (handle_i == '0) begin
                res_d.status = ST_INVALID;
                state_d      = S_DONE;
                launch_d     = 1'b0;
              end else if (nf_q == DEPTH_PTR) begin
                res_d.status = ST_FULL;
                state_d      = S_DONE;
                launch_d     = 1'b0;
              end else begin
                ctl_d.wr_en   = 1'b1;
                ctl_d.scan_en = 1'b1;
                ctl_d.wr_addr = SLOT_W'(nf_q);
                ctl_d.wr_data = handle_i;
              end
            end
            CMD_CLOSE: begin
              if (!in_rng) begin
                res_d.status = ST_INVALID;
                state_d      = S_DONE;
                launch_d     = 1'b0;
              end else begin
                ctl_d.clr_en = 1'b1;
              end
            end
            CMD_LOOKUP, CMD_DUP: begin
              if (!in_rng) begin
                res_d.status = ST_INVALID;
                state_d      = S_DONE;
                launch_d     = 1'b0;
              end
            end
          endcase
        end
      end
      S_PASS1: begin
        if (tail_i.valid) begin
          state_d = S_DONE;
          unique case (cmd_q)
            CMD_ALLOC: begin
              nf_d           = nf_scan;
              res_d.slot_out = ctl_q.wr_addr;
            end
            CMD_LOOKUP: begin
              res_d.handle_out = tail_i.rd_a;
            end
            CMD_CLOSE: begin
              if (tail_i.rd_a == '0) begin
                res_d.status = ST_INVALID;
              end else begin
                if (!is_console(tail_i.rd_a)) begin
                  res_d.release_res     = 1'b1;
                  res_d.released_handle = tail_i.rd_a;
                end
                if (slot_ext < nf_ext) begin
                  nf_d = PTR_W'(slot_q);
                end
              end
            end
            CMD_DUP: begin
              if (tail_i.rd_a == '0) begin
                res_d.status = ST_INVALID;
              end else if (slot_q == tgt_q) begin
                res_d.slot_out = tgt_q;
              end else if (!tgt_rng) begin
                res_d.status = ST_INVALID;
              end else begin
                if ((tail_i.rd_b != '0) && !is_console(tail_i.rd_b)) begin
                  res_d.release_res     = 1'b1;
                  res_d.released_handle = tail_i.rd_b;
                end
                res_d.add_reference = !is_console(tail_i.rd_a);
                res_d.slot_out      = tgt_q;
                ctl_d.clr_en        = 1'b0;
                ctl_d.wr_en         = 1'b1;
                ctl_d.wr_addr       = tgt_q;
                ctl_d.wr_data       = tail_i.rd_a;
                ctl_d.scan_en       = EXT_W'(nf_dup) == tgt_ext;
                nf_d                = nf_dup;
                launch_d            = 1'b1;
                state_d             = S_PASS2;
              end
            end
          endcase
        end
      end
      S_PASS2: begin
        if (tail_i.valid) begin
          if (ctl_q.scan_en) begin
            nf_d = nf_scan;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nf_q        <= PTR_W'(2);
      ctl_q       <= '0;
      launch_q    <= 1'b0;
      cmd_q       <= CMD_ALLOC;
      slot_q      <= '0;
      tgt_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nf_q        <= nf_d;
      ctl_q       <= ctl_d;
      launch_q    <= launch_d;
      cmd_q       <= cmd_d;
      slot_q      <= slot_d;
      tgt_q       <= tgt_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign slot_out_o        = out_q.slot_out;
  assign handle_out_o      = out_q.handle_out;
  assign release_res_o     = out_q.release_res;
  assign released_handle_o = out_q.released_handle;
  assign add_reference_o   = out_q.add_reference;
  assign ctl_o             = ctl_q;

  always_comb begin
    inject_o       = '0;
    inject_o.valid = launch_q;
  end

  a_tail_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_i.valid |-> (state_q == S_PASS1 || state_q == S_PASS2))
    else $error("token left the chain outside a pass");

  a_nf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= DEPTH_PTR)
    else $error("free pointer beyond table depth");

  a_wr_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_q.wr_en && ctl_q.clr_en))
    else $error("write and clear in the same pass");

  a_launch_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |=> !launch_q)
    else $error("two tokens launched back to back");

endmodule

`default_nettype wire

// File: src/lowest_free_descriptor_table_unit.sv
// Top level: row of table cells driven by the command sequencer.
//
// Descriptor table of TABLE_DEPTH 16-bit handles with a lowest-free pointer;
// slots 0 and 1 hold the console handles 1 and 2 after reset. Every accepted
// beat that touches the table sends a token down the row of TABLE_DEPTH
// cells, one cell per cycle; a cell reads, clears or writes its slot and
// continues the free-slot hunt as the token passes. A duplicate that writes its
// target needs a second pass; a command rejected on its fields alone sends no
// token. The length of the cell row sets how long a pass takes. One command
// is in flight at a time; the next beat can be accepted in the cycle after its
// result is loaded into the output register, and a stalled result holds off
// that load.
`default_nettype none

module lowest_free_descriptor_table_unit #(
  parameter int unsigned TABLE_DEPTH = lfdt_pkg::DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [lfdt_pkg::CMD_W-1:0]    command_i,
  input  wire logic [lfdt_pkg::HANDLE_W-1:0] handle_i,
  input  wire logic [lfdt_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [lfdt_pkg::SLOT_W-1:0]   target_slot_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [lfdt_pkg::STATUS_W-1:0]      status_o,
  output logic [lfdt_pkg::SLOT_W-1:0]        slot_out_o,
  output logic [lfdt_pkg::HANDLE_W-1:0]      handle_out_o,
  output logic                               release_res_o,
  output logic [lfdt_pkg::HANDLE_W-1:0]      released_handle_o,
  output logic                               add_reference_o
);
  import lfdt_pkg::*;

  ctl_t                   ctl;
  link_t                  chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] tok_v;

  lfdt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .handle_i         (handle_i),
    .slot_i           (slot_i),
    .target_slot_i    (target_slot_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .slot_out_o       (slot_out_o),
    .handle_out_o     (handle_out_o),
    .release_res_o    (release_res_o),
    .released_handle_o(released_handle_o),
    .add_reference_o  (add_reference_o),
    .ctl_o            (ctl),
    .inject_o         (chain[0]),
    .tail_i           (chain[TABLE_DEPTH])
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lfdt_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .link_i(chain[i]),
      .link_o(chain[i+1])
    );
    assign tok_v[i] = chain[i+1].valid;
  end

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_v))
    else $error("more than one token in the cell row");

endmodule

`default_nettype wire
